/* hw/rtl/bba_pkg.sv */
// Shared types, codes and fixed widths for the bitmap block allocator.
package bba_pkg;

  localparam int unsigned NUM_W         = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned CNT_W         = 13;
  localparam int unsigned CFG_ADDR_W    = 1;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned IN_TDATA_W    = 32;
  localparam int unsigned OUT_TDATA_W   = 48;
  localparam int unsigned ENTRIES_RESET = 4096;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ENTRIES = 1'b0,
    CFG_BASE    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    clear_step;
    logic    load_req;
    logic    scan_step;
    logic    free_rd;
    logic    free_chk;
    logic    write_en;
    logic    res_load;
    status_e res_status;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_hit;
    logic scan_miss;
    logic range_bad;
    logic bit_set;
    logic out_busy;
  } dp_stat_t;

endpackage

/* hw/rtl/bba_datapath.sv */
// Datapath: config registers, bitmap memory, word scan, count and result/output registers.
module bba_datapath import bba_pkg::*; #(
  parameter int unsigned ENTRIES   = 4096,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  req_mode_i,
  input  logic [NUM_W-1:0]      req_number_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [NUM_W-1:0]      out_number_o,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic [CNT_W-1:0]      out_free_o
);

  // WORD_BITS is a power of two: word/bit split is a shift and a mask
  localparam int unsigned WORD_COUNT = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned LOG_WB     = $clog2(WORD_BITS);
  localparam int unsigned WA         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned CMP_W      = (IDX_W + 2 > CNT_W + 1) ? IDX_W + 2 : CNT_W + 1;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);
  localparam logic [WA-1:0]    LAST_WORD = WA'(WORD_COUNT - 1);

  logic [CNT_W-1:0]     entries_q;
  logic [NUM_W-1:0]     base_q;
  logic                 mode_q;
  logic [NUM_W-1:0]     num_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [WA-1:0]        clr_addr_q;
  logic [WA-1:0]        scan_rd_q;
  logic [WA-1:0]        chk_w_q;
  logic                 chk_v_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic [WA-1:0]        wr_addr_q;
  logic [WORD_BITS-1:0] wr_data_q;
  logic [WORD_BITS-1:0] rd_data_q;
  status_e              res_status_q;
  logic [NUM_W-1:0]     res_num_q;
  logic                 out_valid_q;
  logic [NUM_W-1:0]     out_num_q;
  status_e              out_status_q;
  logic [CNT_W-1:0]     out_free_q;

  logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];

  logic [CNT_W-1:0]     lim;
  logic                 lim_zero;
  logic [CNT_W-1:0]     lim_m1;
  logic [CMP_W-1:0]     last_w;
  logic [NUM_W:0]       diff;
  logic [IDX_W-1:0]     fr_idx;
  logic [IDX_W-1:0]     fr_idx_sh;
  logic [WA-1:0]        fr_word;
  logic [LOG_WB-1:0]    fr_bit;
  logic                 zero_found;
  logic [LOG_WB-1:0]    zero_pos;
  logic [CMP_W-1:0]     cand;
  logic                 in_range;
  logic                 rd_en;
  logic [WA-1:0]        rd_addr;
  logic                 mem_we;
  logic [WA-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [CNT_W-1:0]     free_now;

  // effective pool size, capped at the bitmap size
  always_comb begin
    if (CMP_W'(entries_q) > ENTRIES_C) begin
      lim = ENTRIES_C[CNT_W-1:0];
    end else begin
      lim = entries_q;
    end
  end

  assign lim_zero = (lim == '0);
  assign lim_m1   = lim - CNT_W'(1);
  assign last_w   = CMP_W'(lim_m1) >> LOG_WB;

  // free request: range check and index split
  assign diff      = {1'b0, num_q} - {1'b0, base_q};
  assign fr_idx    = diff[IDX_W-1:0];
  assign fr_idx_sh = fr_idx >> LOG_WB;
  assign fr_word   = fr_idx_sh[WA-1:0];
  assign fr_bit    = fr_idx[LOG_WB-1:0];

  // lowest clear bit in the word just read
  always_comb begin
    zero_found = 1'b0;
    zero_pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data_q[i]) begin
        zero_found = 1'b1;
        zero_pos   = LOG_WB'(i);
      end
    end
  end

  assign cand     = (CMP_W'(chk_w_q) << LOG_WB) | CMP_W'(zero_pos);
  assign in_range = zero_found && (cand < CMP_W'(lim));

  assign stat_o.clear_last = (clr_addr_q == LAST_WORD);
  assign stat_o.scan_hit   = chk_v_q && in_range && !lim_zero;
  assign stat_o.scan_miss  = lim_zero ||
                             (chk_v_q && !in_range &&
                              (zero_found || (CMP_W'(chk_w_q) == last_w)));
  assign stat_o.range_bad  = diff[NUM_W] || (diff[NUM_W-1:0] >= NUM_W'(lim));
  assign stat_o.bit_set    = rd_data_q[fr_bit];
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  // bitmap memory ports
  assign rd_en     = cmd_i.scan_step || cmd_i.free_rd;
  assign rd_addr   = cmd_i.free_rd ? fr_word : scan_rd_q;
  assign mem_we    = cmd_i.clear_step || cmd_i.write_en;
  assign mem_waddr = cmd_i.clear_step ? clr_addr_q : wr_addr_q;
  assign mem_wdata = cmd_i.clear_step ? '0 : wr_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= bitmap_mem[rd_addr];
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= CNT_W'(ENTRIES_RESET);
      base_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ENTRIES: entries_q <= cfg_data_i[CNT_W-1:0];
        CFG_BASE:    base_q    <= cfg_data_i[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // control state: clear sweep, scan pointer, count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      scan_rd_q   <= '0;
      chk_v_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_addr_q <= clr_addr_q + WA'(1);
      end
      if (cmd_i.load_req) begin
        scan_rd_q <= '0;
        chk_v_q   <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_rd_q <= scan_rd_q + WA'(1);
        chk_v_q   <= 1'b1;
      end else begin
        chk_v_q <= 1'b0;
      end
      if (cmd_i.write_en) begin
        if (mode_q == MODE_ALLOC) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end else if (cnt_q != '0) begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign free_now = (lim > cnt_q) ? (lim - cnt_q) : '0;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q <= req_mode_i;
      num_q  <= req_number_i;
    end
    if (cmd_i.scan_step) begin
      chk_w_q <= scan_rd_q;
    end
    if (cmd_i.scan_step && stat_o.scan_hit) begin
      hit_idx_q <= cand[IDX_W-1:0];
      wr_addr_q <= chk_w_q;
      wr_data_q <= rd_data_q | (WORD_BITS'(1) << zero_pos);
    end else if (cmd_i.free_chk) begin
      wr_addr_q <= fr_word;
      wr_data_q <= rd_data_q & ~(WORD_BITS'(1) << fr_bit);
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      if ((cmd_i.res_status == ST_OK) && (mode_q == MODE_ALLOC)) begin
        res_num_q <= base_q + NUM_W'(hit_idx_q);
      end else begin
        res_num_q <= '0;
      end
    end
    if (cmd_i.out_load) begin
      out_num_q    <= res_num_q;
      out_status_q <= res_status_q;
      out_free_q   <= free_now;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_number_o = out_num_q;
  assign out_status_o = out_status_q;
  assign out_free_o   = out_free_q;

endmodule

/* hw/rtl/bba_ctrl.sv */
// Controller state machine: sequences clear sweep, scan, free check and write-back.
module bba_ctrl import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_mode_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = (in_mode_i == MODE_FREE) ? S_FREE_RD : S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_hit) begin
          state_d = S_WRITE;
        end else if (stat_i.scan_miss) begin
          state_d = S_DONE;
        end
      end
      S_FREE_RD: begin
        state_d = stat_i.range_bad ? S_DONE : S_FREE_CHK;
      end
      S_FREE_CHK: begin
        state_d = stat_i.bit_set ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ST_OK;
    in_ready_o       = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (!stat_i.scan_hit && stat_i.scan_miss) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_FULL;
        end
      end
      S_FREE_RD: begin
        if (stat_i.range_bad) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_RANGE;
        end else begin
          cmd_o.free_rd = 1'b1;
        end
      end
      S_FREE_CHK: begin
        cmd_o.free_chk = 1'b1;
        if (!stat_i.bit_set) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOT_ALLOC;
        end
      end
      S_WRITE: begin
        cmd_o.write_en   = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_OK;
      end
      S_DONE: begin
        cmd_o.out_load = !stat_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/bitmap_block_allocator.sv */
// Top level of the first-fit bitmap block allocator.
//
//  channel   direction  contents
//  s_axis    in         tuser: mode; tdata: block_number
//  m_axis    out        tdata: allocated_number, status, free_count
//  cfg       in         write only: 0 entries_in_use, 1 base_number
//
// Allocate reads the bitmap from word 0, one word read per cycle, up to the word holding the
// first clear bit, then writes it back; pool full ends at the last word examined. A free reads
// the word, checks the bit and writes it back; out of range or not allocated ends it early.
// After reset a clearing pass writes WORD_COUNT words (64 at the defaults) before the first
// request is taken; config writes are taken throughout.
// A finished result waits in the output register while the next request runs; a newer result
// holds in the result register until the output register frees.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int unsigned ENTRIES   = 4096,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] block_number
  input  logic                   s_axis_tuser,   // [0] mode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] allocated_number, [33:32] status,
                                                 // [46:34] free_count, [47] zero
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [NUM_W-1:0]     out_number;
  logic [STATUS_W-1:0]  out_status;
  logic [CNT_W-1:0]     out_free;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bba_datapath #(
    .ENTRIES   (ENTRIES),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_mode_i   (s_axis_tuser),
    .req_number_i (s_axis_tdata[NUM_W-1:0]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_number_o (out_number),
    .out_status_o (out_status),
    .out_free_o   (out_free)
  );

  assign m_axis_tdata = {1'b0, out_free, out_status, out_number};

  // one request in flight: an accepted transfer closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a request is in flight");

  // failed requests return number zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] != ST_OK) |-> (m_axis_tdata[31:0] == '0))
    else $error("nonzero number on failed request");

  // a full scan means every block below the limit is counted as used
  a_full_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] == ST_FULL) |-> (m_axis_tdata[46:34] == '0))
    else $error("pool full reported with free blocks left");

endmodule
